[src/rawst_pkg.sv]
// ----------------------------------------------------------------------------
// rawst_pkg: shared types and constants of the weighted slope total unit
// Field widths, register indexes, and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package rawst_pkg;

   localparam int ALT_W      = 21;
   localparam int IDX_W      = 10;
   localparam int COST_W     = 20;
   localparam int STEP_W     = 48;
   localparam int TOTAL_W    = 63;
   localparam int ACC_W      = 64;
   localparam int HALF_W     = STEP_W / 2;
   localparam int PART_W     = HALF_W + COST_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int DEFAULT_MAX_POINTS = 1024;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_COST_RISE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COST_FALL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_POINT = 2'd2;

   localparam logic [COST_W-1:0] COST_RISE_RESET  = 20'd1;
   localparam logic [COST_W-1:0] COST_FALL_RESET  = 20'd1;
   localparam logic [IDX_W-1:0]  LAST_POINT_RESET = 10'd1023;

   // Operation codes of the input transaction.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_RANGE = 1'b1;

   typedef logic signed [ALT_W-1:0]   alt_type;
   typedef logic signed [STEP_W-1:0]  step_type;
   typedef logic signed [TOTAL_W-1:0] total_type;
   typedef logic        [ACC_W-1:0]   acc_type;

   typedef struct packed {
      logic [COST_W-1:0] cost_rise;
      logic [COST_W-1:0] cost_fall;
      logic [IDX_W-1:0]  last_point;
   } cfg_type;

   typedef struct packed {
      logic capture;     // latch the accepted input transaction
      logic load_first;  // first altitude: remember it only
      logic load_step;   // write a loaded step and take it as operand
      logic rd;          // read the step at the selected index
      logic fetch;       // take the read step, write its updated value
      logic mul;         // partial products of the operand magnitude
      logic sum;         // combine partial products
      logic acc;         // apply the contribution to the running total
      logic acc_remove;  // remove rather than add the contribution
      logic move_new;    // operand becomes the updated step
      logic sel_second;  // index is right+1 rather than left
      logic emit;        // load the response register
   } cmd_type;

   typedef struct packed {
      logic is_range;
      logic count_zero;
      logic count_ok;
      logic left_ok;
      logic right_ok;
   } status_type;

endpackage

[src/range_add_weighted_slope_total_unit.sv]
// ----------------------------------------------------------------------------
// range_add_weighted_slope_total_unit: difference-array range add with a
// weighted slope total
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage. Transactions arrive on the req_ channel (valid/ready). A load
// transaction (req_op = 0) streams the altitude of the next point, from
// point 0 to last_point, and produces no response. A range-add transaction
// (req_op = 1) adds req_delta to points req_left..req_right and returns the
// updated 63-bit weighted slope total on the rsp_ channel.
// Timing. One transaction is in work at a time. A load of a step passes
// through multiply, sum and accumulate before the next acceptance; the
// first point and an ignored load go straight back to idle. A range add
// works on each step it changes (read, fetch and write back, then multiply,
// sum and accumulate for the old and the new contribution), and then its
// total shows on rsp_valid once the output register is free.
// The response sits in an output register, so the next transaction is
// accepted while a result waits; a stalled receiver only holds the unit
// when the next result is ready to be written.
// Reset clears the load count, the total and the registers to their
// defaults. The step store is not cleared; loads define its entries.
// ----------------------------------------------------------------------------
module range_add_weighted_slope_total_unit #(
   parameter int MAX_POINTS = rawst_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  rawst_pkg::alt_type               req_altitude,
   input  logic [rawst_pkg::IDX_W-1:0]      req_left,
   input  logic [rawst_pkg::IDX_W-1:0]      req_right,
   input  rawst_pkg::alt_type               req_delta,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rawst_pkg::total_type             rsp_total,
   input  logic                             csr_write_en,
   input  logic [rawst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rawst_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rawst_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   // Configuration registers. Writes to indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_COST_RISE:  cfg_in.cost_rise  = csr_wdata[COST_W-1:0];
            CSR_COST_FALL:  cfg_in.cost_fall  = csr_wdata[COST_W-1:0];
            CSR_LAST_POINT: cfg_in.last_point = csr_wdata[IDX_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cost_rise  <= COST_RISE_RESET;
         cfg_ff.cost_fall  <= COST_FALL_RESET;
         cfg_ff.last_point <= LAST_POINT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The sequencer decides each cycle's operation from the datapath status.
   rawst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath captures the transaction, holds the step store and total.
   rawst_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .status       (status),
      .req_op       (req_op),
      .req_altitude (req_altitude),
      .req_left     (req_left),
      .req_right    (req_right),
      .req_delta    (req_delta),
      .rsp_total    (rsp_total)
   );

endmodule

[src/rawst_datapath.sv]
// ----------------------------------------------------------------------------
// rawst_datapath: step store, multiplier and running total
// Holds the difference store, the load state, a two-half multiplier and
// the 64-bit running total, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module rawst_datapath #(
   parameter int MAX_POINTS = rawst_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rawst_pkg::cfg_type        cfg,
   input  rawst_pkg::cmd_type        cmd,
   output rawst_pkg::status_type     status,
   input  logic                      req_op,
   input  rawst_pkg::alt_type        req_altitude,
   input  logic [rawst_pkg::IDX_W-1:0] req_left,
   input  logic [rawst_pkg::IDX_W-1:0] req_right,
   input  rawst_pkg::alt_type        req_delta,
   output rawst_pkg::total_type      rsp_total
);
   import rawst_pkg::*;

   localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int CMPW = (CW > IDX_W + 1) ? CW : IDX_W + 1;
   localparam logic [CMPW-1:0] MAXP = CMPW'(MAX_POINTS);

   // Captured transaction.
   logic                 op_ff;
   alt_type              alt_ff;
   logic [IDX_W-1:0]     left_ff;
   logic [IDX_W-1:0]     right_ff;
   alt_type              delta_ff;

   // Load state.
   alt_type              prev_ff, prev_in;
   logic [CW-1:0]        count_ff, count_in;

   // Step store.
   step_type             mem [MAX_POINTS];
   step_type             rd_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_addr;
   step_type             mem_wdata;

   // Arithmetic.
   step_type             opnd_ff, opnd_in;
   step_type             new_ff;
   logic                 pos_ff;
   logic [PART_W-1:0]    lo_ff, hi_ff;
   acc_type              prod_ff;
   acc_type              total_ff, total_in;
   total_type            rsp_total_ff;

   logic [CMPW-1:0]      lp_ext, left_ext, right1_ext, idx_ext, count_ext;
   logic signed [ALT_W:0] load_diff;
   step_type             load_d;
   logic signed [ALT_W:0] amount;
   logic signed [STEP_W:0] upd_sum;
   step_type             upd_sat;
   logic                 opnd_pos;
   logic [STEP_W-1:0]    mag;
   logic [COST_W-1:0]    weight;

   function automatic logic index_ok(input logic [CMPW-1:0] i,
                                     input logic [CMPW-1:0] lp);
      return (i != '0) && (i <= lp) && (i < MAXP);
   endfunction

   assign lp_ext     = CMPW'(cfg.last_point);
   assign left_ext   = CMPW'(left_ff);
   assign right1_ext = CMPW'(right_ff) + CMPW'(1);
   assign count_ext  = CMPW'(count_ff);
   assign idx_ext    = cmd.sel_second ? right1_ext : left_ext;

   assign status.is_range   = (op_ff == OP_RANGE);
   assign status.count_zero = (count_ff == '0);
   assign status.count_ok   = index_ok(count_ext, lp_ext);
   assign status.left_ok    = index_ok(left_ext, lp_ext);
   assign status.right_ok   = (right_ff < cfg.last_point) && (right1_ext < MAXP);

   // Step produced by a load; the 22-bit difference never saturates.
   assign load_diff = {alt_ff[ALT_W-1], alt_ff} - {prev_ff[ALT_W-1], prev_ff};
   assign load_d    = {{(STEP_W-ALT_W-1){load_diff[ALT_W]}}, load_diff};

   // Updated step of a range add, saturated to the step width.
   assign amount  = cmd.sel_second ? -{delta_ff[ALT_W-1], delta_ff}
                                   :  {delta_ff[ALT_W-1], delta_ff};
   assign upd_sum = {rd_ff[STEP_W-1], rd_ff}
                  + {{(STEP_W-ALT_W){amount[ALT_W]}}, amount};
   always_comb begin
      if (upd_sum[STEP_W] != upd_sum[STEP_W-1]) begin
         upd_sat = upd_sum[STEP_W] ? {1'b1, {(STEP_W-1){1'b0}}}
                                   : {1'b0, {(STEP_W-1){1'b1}}};
      end else begin
         upd_sat = upd_sum[STEP_W-1:0];
      end
   end

   assign mem_we    = cmd.load_step | cmd.fetch;
   assign mem_addr  = cmd.load_step ? count_ext[AW-1:0] : idx_ext[AW-1:0];
   assign mem_wdata = cmd.load_step ? load_d : upd_sat;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.rd) begin
         rd_ff <= mem[idx_ext[AW-1:0]];
      end
   end

   // Load state.
   always_comb begin
      prev_in  = prev_ff;
      count_in = count_ff;
      if (cmd.load_first) begin
         prev_in  = alt_ff;
         count_in = CW'(1);
      end else if (cmd.load_step) begin
         prev_in  = alt_ff;
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         alt_ff   <= req_altitude;
         left_ff  <= req_left;
         right_ff <= req_right;
         delta_ff <= req_delta;
      end
   end

   // Multiplier: magnitude split in two halves, each times a 20-bit weight.
   assign opnd_pos = !opnd_ff[STEP_W-1] && (opnd_ff != '0);
   assign mag      = opnd_ff[STEP_W-1] ? STEP_W'(-opnd_ff) : STEP_W'(opnd_ff);
   assign weight   = opnd_pos ? cfg.cost_rise : cfg.cost_fall;

   always_comb begin
      opnd_in = opnd_ff;
      if (cmd.load_step) begin
         opnd_in = load_d;
      end else if (cmd.fetch) begin
         opnd_in = rd_ff;
      end else if (cmd.move_new) begin
         opnd_in = new_ff;
      end
   end

   // A positive step's contribution is the negated product, so it is
   // subtracted when added and added when removed.
   always_comb begin
      total_in = total_ff;
      if (cmd.acc) begin
         if (pos_ff ^ cmd.acc_remove) begin
            total_in = total_ff - prod_ff;
         end else begin
            total_in = total_ff + prod_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      if (cmd.fetch) begin
         new_ff <= upd_sat;
      end
      if (cmd.mul) begin
         pos_ff <= opnd_pos;
         lo_ff  <= PART_W'(mag[HALF_W-1:0]) * PART_W'(weight);
         hi_ff  <= PART_W'(mag[STEP_W-1:HALF_W]) * PART_W'(weight);
      end
      if (cmd.sum) begin
         prod_ff <= {{(ACC_W-PART_W){1'b0}}, lo_ff}
                  + {hi_ff[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}};
      end
      if (cmd.emit) begin
         rsp_total_ff <= total_ff[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   assign rsp_total = rsp_total_ff;

endmodule

[src/rawst_ctrl.sv]
// ----------------------------------------------------------------------------
// rawst_ctrl: sequencer of the weighted slope total unit
// Steps each transaction through load or read-modify-write phases and
// owns the input and response handshakes.
// ----------------------------------------------------------------------------
module rawst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rawst_pkg::status_type status,
   output rawst_pkg::cmd_type    cmd
);
   import rawst_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_RD       = 3'd2;
   localparam logic [2:0] ST_FETCH    = 3'd3;
   localparam logic [2:0] ST_MUL      = 3'd4;
   localparam logic [2:0] ST_SUM      = 3'd5;
   localparam logic [2:0] ST_ACC      = 3'd6;
   localparam logic [2:0] ST_EMIT     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       second_ff, second_in;
   logic       phase_new_ff, phase_new_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      second_in    = second_ff;
      phase_new_in = phase_new_ff;
      cmd          = '0;
      cmd.sel_second = second_ff;
      cmd.acc_remove = !phase_new_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_range) begin
               if (status.left_ok) begin
                  second_in = 1'b0;
                  state_in  = ST_RD;
               end else if (status.right_ok) begin
                  second_in = 1'b1;
                  state_in  = ST_RD;
               end else begin
                  state_in = ST_EMIT;
               end
            end else if (status.count_zero) begin
               cmd.load_first = 1'b1;
               state_in       = ST_IDLE;
            end else if (status.count_ok) begin
               cmd.load_step = 1'b1;
               phase_new_in  = 1'b1;
               state_in      = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch    = 1'b1;
            phase_new_in = 1'b0;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (!phase_new_ff) begin
               cmd.move_new = 1'b1;
               phase_new_in = 1'b1;
               state_in     = ST_MUL;
            end else if (!status.is_range) begin
               state_in = ST_IDLE;
            end else if (!second_ff && status.right_ok) begin
               second_in = 1'b1;
               state_in  = ST_RD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         second_ff    <= 1'b0;
         phase_new_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         phase_new_ff <= phase_new_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A new result never overwrites one that the receiver has not taken.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> rsp_free)
      else $error("response register overwritten while stalled");

   // The old contribution of a step is always followed by its new one.
   a_old_then_new: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && !phase_new_ff) |=> (state_ff == ST_MUL && phase_new_ff))
      else $error("updated step contribution skipped");

   // The step at right+1 is read only when it lies inside the profile.
   a_second_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd && second_ff) |-> status.right_ok)
      else $error("second step read outside the profile");

   // Every accepted transaction is dispatched in the following cycle.
   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted transaction not dispatched");

endmodule
